@@ design/fcpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fcpa_pkg - shared types and constants for the chunk pool allocator
// Transaction payloads, operation and status codes, register indexes and the
// sequencer states.
// ----------------------------------------------------------------------------
package fcpa_pkg;

	localparam int DEF_MAX_CHUNKS = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int ADDR_W     = 32;
	localparam int COUNT_W    = 11;
	localparam int CHUNK_W    = 17;
	localparam int ALIGN_W    = 4;
	localparam int PAD_W      = 15;
	localparam int CSIZE_W    = 18;

	typedef enum logic [1:0] {
		KIND_ALLOC    = 2'd0,
		KIND_FREE     = 2'd1,
		KIND_FREE_ALL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BOUNDS   = 3'd2,
		ST_NULL     = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_BUFFER_BASE   = 2'd0,
		REG_BUFFER_LENGTH = 2'd1,
		REG_CHUNK_BYTES   = 2'd2,
		REG_ALIGN_LOG2    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		kind_t              kind;
		logic [ADDR_W-1:0]  free_address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  chunk_address;
		status_t            status;
		logic [COUNT_W-1:0] free_count;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ALIGN,
		S_BOUND,
		S_EXEC,
		S_POP,
		S_WALK
	} state_t;

endpackage

@@ design/fixed_chunk_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator - fixed-size chunk pool with a LIFO free list
// Free list held as a stack of chunk addresses in one synchronous memory.
// Each command passes the align, bound and exec states; alloc on a non-empty
// stack adds a pop state for the memory read, free all a walk state making
// one memory write per chunk. Region arithmetic precedes each op.
// A new command is taken in the cycle its predecessor's result is strobed.
// Reset leaves the stack empty and the registers at their defaults; results
// cannot be stalled, done is high for exactly one cycle per command.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator #(
	parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  fcpa_pkg::cmd_t                    cmd,
	output logic                              done,
	output fcpa_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fcpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int TOP_W  = $clog2(MAX_CHUNKS + 1);
	localparam int MEM_AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(MAX_CHUNKS);
	localparam int AW  = fcpa_pkg::ADDR_W;
	localparam int PW  = fcpa_pkg::PAD_W;
	localparam int CW  = fcpa_pkg::CSIZE_W;
	localparam int NW  = fcpa_pkg::COUNT_W;
	localparam logic [AW+1:0] LIMIT_W = {2'b01, {AW{1'b0}}};
	localparam logic [AW:0]   LIMIT   = {1'b1, {AW{1'b0}}};

	// configuration registers
	logic [AW-1:0]                       base_q;
	logic [AW-1:0]                       length_q;
	logic [fcpa_pkg::CHUNK_W-1:0]        chunk_q;
	logic [fcpa_pkg::ALIGN_W-1:0]        align_q;

	fcpa_pkg::state_t state_q, state_nxt;
	fcpa_pkg::kind_t  kind_q;
	logic [AW-1:0]    addr_q;

	// region bounds of the current transaction
	logic [AW:0]      b_q;
	logic [AW-1:0]    len_q;
	logic [CW-1:0]    c_q;
	logic [AW:0]      end_q;
	logic [AW:0]      p_q;

	logic [TOP_W-1:0]       top_q;
	logic                   done_q;
	logic [AW-1:0]          res_addr_q;
	fcpa_pkg::status_t      res_status_q;

	logic [31:0] stack_mem [MAX_CHUNKS];
	logic [31:0] rd_q;

	logic [PW-1:0]          msk;
	logic [PW-1:0]          pad;
	logic [AW:0]            abase;
	logic [AW-1:0]          len_raw;
	logic [fcpa_pkg::CHUNK_W-1:0] csel;
	logic [CW-1:0]          csize;
	logic [AW+1:0]          end_sum;
	logic [AW:0]            end_nxt;
	logic [AW:0]            p_nxt;
	logic                   in_region;
	logic                   walk_push;
	logic [TOP_W-1:0]       top_dec;
	logic [TOP_W+NW-1:0]    count_wide;

	logic                   res_load;
	logic [AW-1:0]          res_addr;
	fcpa_pkg::status_t      res_status;
	logic                   top_load;
	logic [TOP_W-1:0]       top_next;
	logic                   mem_we;
	logic [MEM_AW-1:0]      mem_waddr;
	logic [31:0]            mem_wdata;
	logic                   mem_re;
	logic [MEM_AW-1:0]      mem_raddr;
	logic                   p_load;

	assign busy = (state_q != fcpa_pkg::S_IDLE);
	assign done = done_q;

	assign count_wide = {{NW{1'b0}}, top_q};
	assign result.chunk_address = res_addr_q;
	assign result.status        = res_status_q;
	assign result.free_count    = count_wide[NW-1:0];

	// alignment: pad is the two's complement of the low base bits under the mask
	always_comb begin
		msk     = PW'((16'(1) << align_q) - 16'(1));
		pad     = (PW'(0) - base_q[PW-1:0]) & msk;
		abase   = {1'b0, base_q} + (AW+1)'(pad);
		len_raw = (length_q > AW'(pad)) ? (length_q - AW'(pad)) : '0;
		csel    = (chunk_q == '0) ? fcpa_pkg::CHUNK_W'(1) : chunk_q;
		csize   = ({1'b0, csel} + CW'(msk)) & ~CW'(msk);
	end

	// region end, clipped at the top of the address space
	always_comb begin
		end_sum = {1'b0, b_q} + {2'b00, len_q};
		if (b_q[AW]) begin
			end_nxt = b_q;
		end else if (end_sum > LIMIT_W) begin
			end_nxt = LIMIT;
		end else begin
			end_nxt = end_sum[AW:0];
		end
	end

	assign p_nxt     = p_q + (AW+1)'(c_q);
	assign walk_push = (p_nxt <= end_q) && (top_q != TOP_FULL);
	assign in_region = ({1'b0, addr_q} >= b_q) && ({1'b0, addr_q} < end_q);
	assign top_dec   = top_q - 1'b1;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fcpa_pkg::S_IDLE: begin
				if (start) state_nxt = fcpa_pkg::S_ALIGN;
			end
			fcpa_pkg::S_ALIGN: state_nxt = fcpa_pkg::S_BOUND;
			fcpa_pkg::S_BOUND: state_nxt = fcpa_pkg::S_EXEC;
			fcpa_pkg::S_EXEC: begin
				case (kind_q)
					fcpa_pkg::KIND_ALLOC: begin
						state_nxt = (top_q == '0) ? fcpa_pkg::S_IDLE : fcpa_pkg::S_POP;
					end
					fcpa_pkg::KIND_FREE_ALL: state_nxt = fcpa_pkg::S_WALK;
					default: state_nxt = fcpa_pkg::S_IDLE;
				endcase
			end
			fcpa_pkg::S_POP: state_nxt = fcpa_pkg::S_IDLE;
			fcpa_pkg::S_WALK: begin
				if (!walk_push) state_nxt = fcpa_pkg::S_IDLE;
			end
			default: state_nxt = fcpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		res_load   = 1'b0;
		res_addr   = '0;
		res_status = fcpa_pkg::ST_OK;
		top_load   = 1'b0;
		top_next   = top_q;
		mem_we     = 1'b0;
		mem_waddr  = top_q[MEM_AW-1:0];
		mem_wdata  = addr_q;
		mem_re     = 1'b0;
		mem_raddr  = top_dec[MEM_AW-1:0];
		p_load     = 1'b0;
		case (state_q)
			fcpa_pkg::S_EXEC: begin
				case (kind_q)
					fcpa_pkg::KIND_ALLOC: begin
						if (top_q == '0) begin
							res_load   = 1'b1;
							res_status = fcpa_pkg::ST_EMPTY;
						end else begin
							mem_re   = 1'b1;
							top_load = 1'b1;
							top_next = top_dec;
						end
					end
					fcpa_pkg::KIND_FREE: begin
						res_load = 1'b1;
						if (addr_q == '0) begin
							res_status = fcpa_pkg::ST_NULL;
						end else if (!in_region) begin
							res_status = fcpa_pkg::ST_BOUNDS;
						end else if (top_q == TOP_FULL) begin
							res_status = fcpa_pkg::ST_OVERFLOW;
						end else begin
							mem_we   = 1'b1;
							top_load = 1'b1;
							top_next = top_q + 1'b1;
						end
					end
					fcpa_pkg::KIND_FREE_ALL: begin
						top_load = 1'b1;
						top_next = '0;
						p_load   = 1'b1;
					end
					default: res_load = 1'b1;
				endcase
			end
			fcpa_pkg::S_POP: begin
				res_load = 1'b1;
				res_addr = rd_q;
			end
			fcpa_pkg::S_WALK: begin
				if (walk_push) begin
					mem_we    = 1'b1;
					mem_wdata = p_q[AW-1:0];
					top_load  = 1'b1;
					top_next  = top_q + 1'b1;
					p_load    = 1'b1;
				end else begin
					res_load = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			length_q <= '0;
			chunk_q  <= fcpa_pkg::CHUNK_W'(64);
			align_q  <= fcpa_pkg::ALIGN_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				fcpa_pkg::REG_BUFFER_BASE:   base_q   <= cfg_data;
				fcpa_pkg::REG_BUFFER_LENGTH: length_q <= cfg_data;
				fcpa_pkg::REG_CHUNK_BYTES:   chunk_q  <= cfg_data[fcpa_pkg::CHUNK_W-1:0];
				fcpa_pkg::REG_ALIGN_LOG2:    align_q  <= cfg_data[fcpa_pkg::ALIGN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fcpa_pkg::S_IDLE;
			top_q        <= '0;
			done_q       <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= fcpa_pkg::ST_OK;
		end else begin
			state_q <= state_nxt;
			done_q  <= res_load;
			if (top_load) top_q <= top_next;
			if (res_load) begin
				res_addr_q   <= res_addr;
				res_status_q <= res_status;
			end
		end
	end

	// transaction and region registers
	always_ff @(posedge clk) begin
		if (state_q == fcpa_pkg::S_IDLE && start) begin
			kind_q <= cmd.kind;
			addr_q <= cmd.free_address;
		end
		if (state_q == fcpa_pkg::S_ALIGN) begin
			b_q   <= abase;
			len_q <= len_raw;
			c_q   <= csize;
		end
		if (state_q == fcpa_pkg::S_BOUND) end_q <= end_nxt;
		if (p_load) p_q <= (state_q == fcpa_pkg::S_EXEC) ? b_q : p_nxt;
	end

	// free stack memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) stack_mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= stack_mem[mem_raddr];
	end

endmodule

@@ design/fcpa_checker.sv @@
// ----------------------------------------------------------------------------
// fcpa_checker - port-level checks for the chunk pool allocator
// Watches the command and result ports and flags sequencing or result
// inconsistencies.
// ----------------------------------------------------------------------------
module fcpa_checker #(
	parameter int MAX_CHUNKS = fcpa_pkg::DEF_MAX_CHUNKS
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input fcpa_pkg::result_t result
);

	// a result is only strobed once the sequencer is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	// an accepted transaction occupies the block on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not occupy the block");

	// failed outcomes never hand out an address
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != fcpa_pkg::ST_OK) |-> (result.chunk_address == '0))
		else $error("address returned with a failure status");

	// empty pool is reported only with an empty count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == fcpa_pkg::ST_EMPTY) |-> (result.free_count == '0))
		else $error("pool empty with non-zero free count");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(result.free_count) <= 32'(MAX_CHUNKS)))
		else $error("free count above pool size");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker #(.MAX_CHUNKS(MAX_CHUNKS)) u_fcpa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
